FILE: sv/bowm_pkg.sv
package bowm_pkg;

    // Channel count and level width
    localparam int CHANNELS   = 32;
    localparam int LEVEL_BITS = 32;
    localparam int CH_W       = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

    // Packet cost: samples * 10 + 50 bits
    localparam int COST_PER_SAMPLE = 10;
    localparam int COST_HEADER     = 50;
    localparam int COST_W          = 14;

    // Window events are taken while count < limit + slack and count is below 16'hFFFF
    localparam int          WINDOW_SLACK       = 500;
    localparam logic [15:0] WINDOW_LIMIT_RESET = 16'd1024;
    localparam logic [15:0] WINDOW_COUNT_TOP   = 16'hFFFF;

    // Field widths of the stream words
    localparam int IN_W   = 24;
    localparam int OUT_W  = 152;
    localparam int USER_W = 2;

    // Operation codes
    localparam logic [1:0] OP_ADD  = 2'd0;
    localparam logic [1:0] OP_REM  = 2'd1;
    localparam logic [1:0] OP_WIN  = 2'd2;
    localparam logic [1:0] OP_NONE = 2'd3;

    // Result kinds
    localparam logic [1:0] KIND_ACCESS = 2'd0;
    localparam logic [1:0] KIND_TOTAL  = 2'd1;
    localparam logic [1:0] KIND_CHAN   = 2'd2;

    // Command queue
    localparam int Q_DEPTH = 2;
    localparam int Q_PTR_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
    localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

    // Decoded command from the front part
    typedef struct packed {
        logic [1:0]        op;
        logic [4:0]        channel;
        logic              ch_ok;
        logic [COST_W-1:0] cost;
    } cmd_t;

    // One result word
    typedef struct packed {
        logic [1:0]  kind;
        logic [4:0]  channel_index;
        logic [15:0] window_number;
        logic [31:0] channel_level;
        logic [31:0] total_level;
        logic [31:0] total_peak;
        logic [31:0] window_peak;
        logic        underflow;
        logic        last;
    } res_t;

endpackage

FILE: sv/bowm_front.sv
module bowm_front (
    input  logic                     s_tvalid,
    output logic                     s_tready,
    input  logic [bowm_pkg::IN_W-1:0] s_tdata,
    output logic                     q_push,
    output bowm_pkg::cmd_t           q_data,
    input  logic                     q_full
);
    import bowm_pkg::*;

    logic [1:0] op;
    logic [4:0] channel;
    logic [9:0] sample_count;

    // Field split
    assign op           = s_tdata[1:0];
    assign channel      = s_tdata[6:2];
    assign sample_count = s_tdata[16:7];

    // Accept whenever the queue has room; unused opcode is dropped
    assign s_tready = !q_full;
    assign q_push   = s_tvalid && s_tready && (op != OP_NONE);

    // Decode and price the packet
    always_comb
    begin
        q_data.op      = op;
        q_data.channel = channel;
        q_data.ch_ok   = ({1'b0, channel} < 6'(CHANNELS));
        q_data.cost    = COST_W'(sample_count) * COST_W'(COST_PER_SAMPLE)
                         + COST_W'(COST_HEADER);
    end

endmodule

FILE: sv/bowm_cmd_fifo.sv
module bowm_cmd_fifo (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  bowm_pkg::cmd_t push_data,
    output logic           full,
    input  logic           pop,
    output bowm_pkg::cmd_t head,
    output logic           valid
);
    import bowm_pkg::*;

    cmd_t               mem_reg [Q_DEPTH];
    logic [Q_PTR_W-1:0] wr_ptr_reg;
    logic [Q_PTR_W-1:0] wr_ptr_next;
    logic [Q_PTR_W-1:0] rd_ptr_reg;
    logic [Q_PTR_W-1:0] rd_ptr_next;
    logic [Q_CNT_W-1:0] count_reg;
    logic [Q_CNT_W-1:0] count_next;
    logic               do_push;
    logic               do_pop;

    assign full    = (count_reg == Q_CNT_W'(Q_DEPTH));
    assign valid   = (count_reg != '0);
    assign head    = mem_reg[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && valid;

    // Pointer and count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

FILE: sv/bowm_back.sv
module bowm_back (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           cfg_we,
    input  logic [15:0]    cfg_wdata,
    input  logic           q_valid,
    input  bowm_pkg::cmd_t q_head,
    output logic           q_pop,
    output logic           out_valid,
    input  logic           out_ready,
    output bowm_pkg::res_t out_res
);
    import bowm_pkg::*;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_ACC  = 3'd1;
    localparam logic [2:0] S_TOT  = 3'd2;
    localparam logic [2:0] S_RDW  = 3'd3;
    localparam logic [2:0] S_CHN  = 3'd4;

    localparam logic [LEVEL_BITS-1:0] LEVEL_MAX = '1;
    localparam logic [CH_W-1:0]       LAST_IDX  = CH_W'(CHANNELS - 1);

    // Per-channel level and window peak
    logic [LEVEL_BITS-1:0] fill_reg  [CHANNELS];
    logic [LEVEL_BITS-1:0] wpeak_reg [CHANNELS];

    logic [2:0]            state_reg, state_next;
    cmd_t                  cmd_reg, cmd_next;
    logic [LEVEL_BITS-1:0] rd_fill_reg, rd_fill_next;
    logic [LEVEL_BITS-1:0] rd_peak_reg, rd_peak_next;
    logic [CH_W-1:0]       idx_reg, idx_next;
    logic [LEVEL_BITS-1:0] total_fill_reg, total_fill_next;
    logic [LEVEL_BITS-1:0] total_peak_reg, total_peak_next;
    logic [LEVEL_BITS-1:0] total_wpeak_reg, total_wpeak_next;
    logic [15:0]           window_cnt_reg, window_cnt_next;
    logic [15:0]           window_limit_reg;
    logic                  out_valid_reg, out_valid_next;
    res_t                  out_res_reg, out_res_next;

    logic                  slot_free;
    logic                  win_blocked;
    logic [CH_W-1:0]       rd_addr;
    logic [CH_W-1:0]       wr_addr;
    logic                  fill_we;
    logic                  peak_we;
    logic [LEVEL_BITS-1:0] peak_wdata;
    logic [LEVEL_BITS-1:0] cost_l;
    logic [LEVEL_BITS:0]   ch_sum;
    logic [LEVEL_BITS:0]   tot_sum;
    logic                  ch_uf;
    logic                  tot_uf;
    logic                  is_add;
    logic [LEVEL_BITS-1:0] new_fill;
    logic [LEVEL_BITS-1:0] new_tot;
    logic [LEVEL_BITS-1:0] new_tpeak;
    logic [LEVEL_BITS-1:0] new_twpeak;
    logic [LEVEL_BITS-1:0] new_cpeak;

    assign slot_free = !out_valid_reg || out_ready;
    assign out_valid = out_valid_reg;
    assign out_res   = out_res_reg;

    // Window event gate
    assign win_blocked = ({1'b0, window_cnt_reg} >= ({1'b0, window_limit_reg} + 17'(WINDOW_SLACK)))
                         || (window_cnt_reg == WINDOW_COUNT_TOP);

    assign rd_addr = (state_reg == S_IDLE) ? CH_W'(q_head.channel) : idx_reg;
    assign wr_addr = (state_reg == S_CHN) ? idx_reg : CH_W'(cmd_reg.channel);

    // Level arithmetic for an add or remove
    always_comb
    begin
        is_add  = (cmd_reg.op == OP_ADD);
        cost_l  = LEVEL_BITS'(cmd_reg.cost);
        ch_sum  = {1'b0, rd_fill_reg} + {1'b0, cost_l};
        tot_sum = {1'b0, total_fill_reg} + {1'b0, cost_l};
        ch_uf   = (cost_l > rd_fill_reg);
        tot_uf  = (cost_l > total_fill_reg);
        if (is_add)
        begin
            new_fill = ch_sum[LEVEL_BITS] ? LEVEL_MAX : ch_sum[LEVEL_BITS-1:0];
            new_tot  = tot_sum[LEVEL_BITS] ? LEVEL_MAX : tot_sum[LEVEL_BITS-1:0];
        end
        else
        begin
            new_fill = ch_uf ? '0 : rd_fill_reg - cost_l;
            new_tot  = tot_uf ? '0 : total_fill_reg - cost_l;
        end
        new_tpeak  = (is_add && new_tot > total_peak_reg) ? new_tot : total_peak_reg;
        new_twpeak = (is_add && new_tot > total_wpeak_reg) ? new_tot : total_wpeak_reg;
        new_cpeak  = (new_fill > rd_peak_reg) ? new_fill : rd_peak_reg;
    end

    // Sequencer
    always_comb
    begin
        state_next       = state_reg;
        cmd_next         = cmd_reg;
        rd_fill_next     = rd_fill_reg;
        rd_peak_next     = rd_peak_reg;
        idx_next         = idx_reg;
        total_fill_next  = total_fill_reg;
        total_peak_next  = total_peak_reg;
        total_wpeak_next = total_wpeak_reg;
        window_cnt_next  = window_cnt_reg;
        out_valid_next   = out_valid_reg && !out_ready;
        out_res_next     = out_res_reg;
        q_pop            = 1'b0;
        fill_we          = 1'b0;
        peak_we          = 1'b0;
        peak_wdata       = new_cpeak;

        case (state_reg)
            S_IDLE:
            begin
                if (q_valid)
                begin
                    q_pop        = 1'b1;
                    cmd_next     = q_head;
                    rd_fill_next = fill_reg[rd_addr];
                    rd_peak_next = wpeak_reg[rd_addr];
                    if (q_head.op == OP_WIN)
                    begin
                        state_next = win_blocked ? S_IDLE : S_TOT;
                    end
                    else
                    begin
                        state_next = S_ACC;
                    end
                end
            end
            S_ACC:
            begin
                if (slot_free)
                begin
                    out_valid_next              = 1'b1;
                    out_res_next.kind           = KIND_ACCESS;
                    out_res_next.channel_index  = cmd_reg.channel;
                    out_res_next.window_number  = window_cnt_reg;
                    out_res_next.window_peak    = '0;
                    out_res_next.last           = 1'b1;
                    if (cmd_reg.ch_ok)
                    begin
                        fill_we                    = 1'b1;
                        peak_we                    = is_add;
                        total_fill_next            = new_tot;
                        total_peak_next            = new_tpeak;
                        total_wpeak_next           = new_twpeak;
                        out_res_next.channel_level = 32'(new_fill);
                        out_res_next.total_level   = 32'(new_tot);
                        out_res_next.total_peak    = 32'(new_tpeak);
                        out_res_next.underflow     = !is_add && (ch_uf || tot_uf);
                    end
                    else
                    begin
                        out_res_next.channel_level = '0;
                        out_res_next.total_level   = 32'(total_fill_reg);
                        out_res_next.total_peak    = 32'(total_peak_reg);
                        out_res_next.underflow     = 1'b0;
                    end
                    state_next = S_IDLE;
                end
            end
            S_TOT:
            begin
                if (slot_free)
                begin
                    out_valid_next             = 1'b1;
                    out_res_next.kind          = KIND_TOTAL;
                    out_res_next.channel_index = '0;
                    out_res_next.window_number = window_cnt_reg;
                    out_res_next.channel_level = '0;
                    out_res_next.total_level   = 32'(total_fill_reg);
                    out_res_next.total_peak    = 32'(total_peak_reg);
                    out_res_next.window_peak   = 32'(total_wpeak_reg);
                    out_res_next.underflow     = 1'b0;
                    out_res_next.last          = 1'b0;
                    total_wpeak_next           = total_fill_reg;
                    idx_next                   = '0;
                    state_next                 = S_RDW;
                end
            end
            S_RDW:
            begin
                rd_fill_next = fill_reg[rd_addr];
                rd_peak_next = wpeak_reg[rd_addr];
                state_next   = S_CHN;
            end
            S_CHN:
            begin
                if (slot_free)
                begin
                    out_valid_next             = 1'b1;
                    out_res_next.kind          = KIND_CHAN;
                    out_res_next.channel_index = 5'(idx_reg);
                    out_res_next.window_number = window_cnt_reg;
                    out_res_next.channel_level = 32'(rd_fill_reg);
                    out_res_next.total_level   = 32'(total_fill_reg);
                    out_res_next.total_peak    = 32'(total_peak_reg);
                    out_res_next.window_peak   = 32'(rd_peak_reg);
                    out_res_next.underflow     = 1'b0;
                    out_res_next.last          = (idx_reg == LAST_IDX);
                    // reseed this channel's window peak
                    peak_we                    = 1'b1;
                    peak_wdata                 = rd_fill_reg;
                    if (idx_reg == LAST_IDX)
                    begin
                        window_cnt_next = window_cnt_reg + 1'b1;
                        state_next      = S_IDLE;
                    end
                    else
                    begin
                        idx_next   = idx_reg + 1'b1;
                        state_next = S_RDW;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control and totals
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            idx_reg          <= '0;
            total_fill_reg   <= '0;
            total_peak_reg   <= '0;
            total_wpeak_reg  <= '0;
            window_cnt_reg   <= '0;
            window_limit_reg <= WINDOW_LIMIT_RESET;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            idx_reg         <= idx_next;
            total_fill_reg  <= total_fill_next;
            total_peak_reg  <= total_peak_next;
            total_wpeak_reg <= total_wpeak_next;
            window_cnt_reg  <= window_cnt_next;
            out_valid_reg   <= out_valid_next;
            if (cfg_we)
            begin
                window_limit_reg <= cfg_wdata;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        cmd_reg     <= cmd_next;
        rd_fill_reg <= rd_fill_next;
        rd_peak_reg <= rd_peak_next;
        out_res_reg <= out_res_next;
    end

    // Channel register file, cleared at reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < CHANNELS; i++)
            begin
                fill_reg[i]  <= '0;
                wpeak_reg[i] <= '0;
            end
        end
        else
        begin
            if (fill_we)
            begin
                fill_reg[wr_addr] <= new_fill;
            end
            if (peak_we)
            begin
                wpeak_reg[wr_addr] <= peak_wdata;
            end
        end
    end

endmodule

FILE: sv/buffer_occupancy_watermark_monitor.sv
// Channel  | Dir | Handshake          | Content
// s_*      | in  | s_tvalid/s_tready  | packet or window event word
// m_*      | out | m_tvalid/m_tready  | access reply or window peak record
// cfg_*    | in  | cfg_we             | window_limit
//
// An add or remove first fetches the channel entry from the register file,
// then updates it and loads the output register.
// A new-window event gives a total record, then one record per channel
// while the sequencer walks the channel register file.
// Reset clears all levels and peaks at once; no clearing pass.
// A full output register stalls the back end; the 2-entry command queue
// lets the input side keep taking words meanwhile.
module buffer_occupancy_watermark_monitor (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [15:0]                   cfg_wdata,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // operation[1:0], channel[6:2], sample_count[16:7], zero fill
    input  logic [bowm_pkg::IN_W-1:0]     s_tdata,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // channel_index[4:0], window_number[20:5], channel_level[52:21],
    // total_level[84:53], total_peak[116:85], window_peak[148:117],
    // underflow[149], zero fill
    output logic [bowm_pkg::OUT_W-1:0]    m_tdata,
    // kind[1:0]
    output logic [bowm_pkg::USER_W-1:0]   m_tuser,
    output logic                          m_tlast
);
    import bowm_pkg::*;

    logic q_push;
    cmd_t q_data;
    logic q_full;
    logic q_pop;
    cmd_t q_head;
    logic q_valid;
    res_t res;

    bowm_front u_front (
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .q_push   (q_push),
        .q_data   (q_data),
        .q_full   (q_full)
    );

    bowm_cmd_fifo u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_data),
        .full      (q_full),
        .pop       (q_pop),
        .head      (q_head),
        .valid     (q_valid)
    );

    bowm_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .q_valid   (q_valid),
        .q_head    (q_head),
        .q_pop     (q_pop),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_res   (res)
    );

    // Output word packing
    assign m_tdata = {2'b00, res.underflow, res.window_peak, res.total_peak,
                      res.total_level, res.channel_level, res.window_number,
                      res.channel_index};
    assign m_tuser = res.kind;
    assign m_tlast = res.last;

endmodule

FILE: sv/bowm_checker.sv
module bowm_checker (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        m_tvalid,
    input logic                        m_tready,
    input logic [bowm_pkg::OUT_W-1:0]  m_tdata,
    input logic [bowm_pkg::USER_W-1:0] m_tuser,
    input logic                        m_tlast
);
    import bowm_pkg::*;

    // An access reply is always the only word of its event
    a_access_last: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tuser == KIND_ACCESS) |-> m_tlast)
        else $error("access reply without tlast");

    // The total record always opens a run of channel records
    a_total_not_last: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tuser == KIND_TOTAL) |-> !m_tlast
            && (m_tdata[4:0] == 5'd0) && (m_tdata[52:21] == 32'd0))
        else $error("malformed total record");

    // Access replies carry no window peak
    a_access_no_wpeak: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tuser == KIND_ACCESS) |-> (m_tdata[148:117] == 32'd0))
        else $error("window peak set in access reply");

    // The all-time peak never trails the current total
    a_peak_covers_total: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[116:85] >= m_tdata[84:53]))
        else $error("total peak below total level");

    // A stalled word holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("output word changed under stall");

endmodule

bind buffer_occupancy_watermark_monitor bowm_checker u_bowm_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);
